>>> hw/rtl/vpr_pkg.sv
// Package for the vector polar/rectangular unit: transaction types, command
// codes, CORDIC constants, the arctangent table and the saturation helper.
// No dependencies.
package vpr_pkg;

  localparam int DW            = 32;   // payload word width
  localparam int XW            = 58;   // CORDIC x/y datapath width
  localparam int ZW            = 36;   // CORDIC angle width, Q2.30 plus headroom
  localparam int ZIW           = 56;   // incoming angle after scaling to Q2.30
  localparam int MW            = 35;   // multiplier operand width
  localparam int PW            = 70;   // multiplier product width
  localparam int RW            = 72;   // rounding and saturation width
  localparam int ATAN_LEN      = 30;
  localparam int VEC_PRESCALE  = 22;
  localparam int HI_SHIFT      = 26;

  localparam logic [2:0] CMD_P2R   = 3'd0;
  localparam logic [2:0] CMD_R2P   = 3'd1;
  localparam logic [2:0] CMD_ADD   = 3'd2;
  localparam logic [2:0] CMD_SUB   = 3'd3;
  localparam logic [2:0] CMD_NEG   = 3'd4;
  localparam logic [2:0] CMD_SCALE = 3'd5;

  localparam logic signed [ZW-1:0] Q30_PI      = 36'sd3373259426;
  localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
  localparam logic signed [ZW-1:0] CORDIC_K    = 36'sd652032874;

  localparam logic signed [RW-1:0] SAT_MAX = 72'sd2147483647;
  localparam logic signed [RW-1:0] SAT_MIN = -72'sd2147483648;

  typedef struct packed {
    logic [2:0]           command;
    logic signed [DW-1:0] first_a;
    logic signed [DW-1:0] first_b;
    logic signed [DW-1:0] second_a;
    logic signed [DW-1:0] second_b;
    logic signed [DW-1:0] scale_factor;
  } in_t;

  typedef struct packed {
    logic signed [DW-1:0] result_a;
    logic signed [DW-1:0] result_b;
    logic                 overflow;
  } out_t;

  typedef struct packed {
    logic [DW-1:0] val;
    logic          ov;
  } sat_t;

  // atan(2^-i) in Q2.30
  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    v = '0;
    unique case (idx)
      5'd0:  v = 36'sh03243F6A8;
      5'd1:  v = 36'sh01DAC6705;
      5'd2:  v = 36'sh00FADBAFC;
      5'd3:  v = 36'sh007F56EA6;
      5'd4:  v = 36'sh003FEAB76;
      5'd5:  v = 36'sh001FFD55B;
      5'd6:  v = 36'sh000FFFAAA;
      5'd7:  v = 36'sh0007FFF55;
      5'd8:  v = 36'sh0003FFFEA;
      5'd9:  v = 36'sh0001FFFFD;
      5'd10: v = 36'sh0000FFFFF;
      5'd11: v = 36'sh00007FFFF;
      5'd12: v = 36'sh00003FFFF;
      5'd13: v = 36'sh00001FFFF;
      5'd14: v = 36'sh00000FFFF;
      5'd15: v = 36'sh000007FFF;
      5'd16: v = 36'sh000003FFF;
      5'd17: v = 36'sh000001FFF;
      5'd18: v = 36'sh000000FFF;
      5'd19: v = 36'sh0000007FF;
      5'd20: v = 36'sh0000003FF;
      5'd21: v = 36'sh0000001FF;
      5'd22: v = 36'sh0000000FF;
      5'd23: v = 36'sh00000007F;
      5'd24: v = 36'sh00000003F;
      5'd25: v = 36'sh00000001F;
      5'd26: v = 36'sh00000000F;
      5'd27: v = 36'sh000000008;
      5'd28: v = 36'sh000000004;
      5'd29: v = 36'sh000000002;
      default: v = '0;
    endcase
    return v;
  endfunction

  // clamp a wide signed value into 32 bits and flag the clamp
  function automatic sat_t sat32(input logic signed [RW-1:0] v);
    sat_t r;
    r.ov  = 1'b0;
    r.val = v[DW-1:0];
    if (v > SAT_MAX) begin
      r.val = SAT_MAX[DW-1:0];
      r.ov  = 1'b1;
    end else if (v < SAT_MIN) begin
      r.val = SAT_MIN[DW-1:0];
      r.ov  = 1'b1;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/vpr_if.sv
// Valid/ready channel carrying one transaction of payload type T.
// Used with the transaction types of vpr_pkg.
interface vpr_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/vector_polar_rect_unit_core.sv
// Vector unit: polar/rectangular conversion by unrolled CORDIC, add, subtract,
// negate and scale in signed fixed point. Depends on vpr_pkg and vpr_if.
// Stages: prepare, one per CORDIC step (at most ATAN_LEN), multiply, and
// round/saturate into the output register. Throughput: one transaction per
// cycle while the sink is ready; a stage advances when it is empty or the one after it advances.
// Reset clears the stage valid bits only; data registers are not reset.
module vector_polar_rect_unit_core #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 16
) (
  input logic    clk,
  input logic    rst,
  vpr_if.sink    in_ch,
  vpr_if.source  out_ch
);

  localparam int NSTEP = (CORDIC_STEPS > vpr_pkg::ATAN_LEN) ? vpr_pkg::ATAN_LEN : CORDIC_STEPS;
  localparam int NS    = NSTEP + 3;
  localparam int LAST  = NS - 1;
  localparam int MUL   = NSTEP + 1;
  localparam int ZSH   = 30 - FRAC_BITS;

  localparam logic signed [vpr_pkg::RW-1:0] RND_30 = 72'sd1 <<< 29;
  localparam logic signed [vpr_pkg::RW-1:0] RND_25 = 72'sd1 <<< 25;
  localparam logic signed [vpr_pkg::RW-1:0] RND_F  = 72'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [vpr_pkg::RW-1:0] RND_Z  = 72'sd1 <<< (ZSH - 1);

  typedef struct packed {
    logic [2:0]         op;
    logic               ov;
    logic               origin;
    logic signed [32:0] a;
    logic signed [31:0] b;
    logic signed [31:0] f;
    logic signed [32:0] da;
    logic signed [32:0] db;
  } side_t;

  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  logic signed [vpr_pkg::XW-1:0] cx [NSTEP+1];
  logic signed [vpr_pkg::XW-1:0] cy [NSTEP+1];
  logic signed [vpr_pkg::ZW-1:0] cz [NSTEP+1];
  side_t                         sd [NSTEP+1];

  logic signed [vpr_pkg::PW-1:0] pa, pb;
  logic signed [vpr_pkg::ZW-1:0] mz;
  side_t                         msd;

  // stall chain: a stage loads when empty or when the next one loads
  always_comb begin
    en[LAST] = !vld[LAST] || out_ch.ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ch.ready  = en[0];
  assign out_ch.valid = vld[LAST];

  // advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_ch.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // prepare: angle clamp and fold, vector prescale, direct sums, differences and negation
  logic signed [vpr_pkg::XW-1:0]  x0, y0, xs, ys;
  logic signed [vpr_pkg::ZW-1:0]  z0;
  logic signed [vpr_pkg::ZIW-1:0] zin, zc;
  side_t                          s0;
  logic                           flip;

  always_comb begin
    zin  = vpr_pkg::ZIW'(signed'(in_ch.data.first_b)) <<< ZSH;
    xs   = vpr_pkg::XW'(signed'(in_ch.data.first_a)) <<< vpr_pkg::VEC_PRESCALE;
    ys   = vpr_pkg::XW'(signed'(in_ch.data.first_b)) <<< vpr_pkg::VEC_PRESCALE;
    zc   = zin;
    flip = 1'b0;
    x0   = '0;
    y0   = '0;
    z0   = '0;
    s0.op     = in_ch.data.command;
    s0.ov     = 1'b0;
    s0.origin = 1'b0;
    s0.a  = 33'(signed'(in_ch.data.first_a));
    s0.b  = in_ch.data.first_b;
    s0.f  = in_ch.data.scale_factor;
    s0.da = '0;
    s0.db = '0;
    unique case (in_ch.data.command)
      vpr_pkg::CMD_P2R: begin
        if (zin > vpr_pkg::ZIW'(vpr_pkg::Q30_PI)) begin
          zc    = vpr_pkg::ZIW'(vpr_pkg::Q30_PI);
          s0.ov = 1'b1;
        end else if (zin < -vpr_pkg::ZIW'(vpr_pkg::Q30_PI)) begin
          zc    = -vpr_pkg::ZIW'(vpr_pkg::Q30_PI);
          s0.ov = 1'b1;
        end
        if (zc > vpr_pkg::ZIW'(vpr_pkg::Q30_HALF_PI)) begin
          z0   = vpr_pkg::ZW'(zc) - vpr_pkg::Q30_PI;
          flip = 1'b1;
        end else if (zc < -vpr_pkg::ZIW'(vpr_pkg::Q30_HALF_PI)) begin
          z0   = vpr_pkg::ZW'(zc) + vpr_pkg::Q30_PI;
          flip = 1'b1;
        end else begin
          z0 = vpr_pkg::ZW'(zc);
        end
        x0 = vpr_pkg::XW'(vpr_pkg::CORDIC_K);
        // fold the half-turn into the magnitude
        if (flip) s0.a = -33'(signed'(in_ch.data.first_a));
      end
      vpr_pkg::CMD_R2P: begin
        // mark the zero vector, whose angle is zero
        s0.origin = (in_ch.data.first_a == '0) && (in_ch.data.first_b == '0);
        if (xs < 0) begin
          z0 = (ys >= 0) ? vpr_pkg::Q30_PI : -vpr_pkg::Q30_PI;
          x0 = -xs;
          y0 = -ys;
        end else begin
          x0 = xs;
          y0 = ys;
        end
      end
      vpr_pkg::CMD_ADD: begin
        s0.da = 33'(signed'(in_ch.data.first_a)) + 33'(signed'(in_ch.data.second_a));
        s0.db = 33'(signed'(in_ch.data.first_b)) + 33'(signed'(in_ch.data.second_b));
      end
      vpr_pkg::CMD_SUB: begin
        s0.da = 33'(signed'(in_ch.data.first_a)) - 33'(signed'(in_ch.data.second_a));
        s0.db = 33'(signed'(in_ch.data.first_b)) - 33'(signed'(in_ch.data.second_b));
      end
      vpr_pkg::CMD_NEG: begin
        s0.da = -33'(signed'(in_ch.data.first_a));
        s0.db = -33'(signed'(in_ch.data.first_b));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      cx[0] <= x0;
      cy[0] <= y0;
      cz[0] <= z0;
      sd[0] <= s0;
    end
  end

  // one CORDIC micro-rotation per stage; rotation mode follows z, vectoring follows y
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    logic                          ccw;
    logic signed [vpr_pkg::XW-1:0] dx, dy, nx, ny;
    logic signed [vpr_pkg::ZW-1:0] at, nz;

    always_comb begin
      ccw = (sd[i].op == vpr_pkg::CMD_P2R) ? !cz[i][vpr_pkg::ZW-1] : cy[i][vpr_pkg::XW-1];
      dx  = cy[i] >>> i;
      dy  = cx[i] >>> i;
      at  = vpr_pkg::atan_q30(5'(i));
      nx  = ccw ? cx[i] - dx : cx[i] + dx;
      ny  = ccw ? cy[i] + dy : cy[i] - dy;
      nz  = ccw ? cz[i] - at : cz[i] + at;
    end

    always_ff @(posedge clk) begin
      if (en[i+1]) begin
        cx[i+1] <= nx;
        cy[i+1] <= ny;
        cz[i+1] <= nz;
        sd[i+1] <= sd[i];
      end
    end
  end

  // multiply: magnitude by cos/sin, CORDIC x by gain (split hi/lo), or scale
  logic signed [vpr_pkg::MW-1:0] ma, mb, mc, md;

  always_comb begin
    ma = '0;
    mb = '0;
    mc = '0;
    md = '0;
    unique case (sd[NSTEP].op)
      vpr_pkg::CMD_P2R: begin
        ma = vpr_pkg::MW'(sd[NSTEP].a);
        mb = vpr_pkg::MW'(cx[NSTEP]);
        mc = vpr_pkg::MW'(sd[NSTEP].a);
        md = vpr_pkg::MW'(cy[NSTEP]);
      end
      vpr_pkg::CMD_R2P: begin
        ma = vpr_pkg::MW'(cx[NSTEP] >>> vpr_pkg::HI_SHIFT);
        mb = vpr_pkg::MW'(vpr_pkg::CORDIC_K);
        mc = vpr_pkg::MW'({1'b0, cx[NSTEP][vpr_pkg::HI_SHIFT-1:0]});
        md = vpr_pkg::MW'(vpr_pkg::CORDIC_K);
      end
      vpr_pkg::CMD_SCALE: begin
        ma = vpr_pkg::MW'(sd[NSTEP].a);
        mb = vpr_pkg::MW'(sd[NSTEP].f);
        mc = vpr_pkg::MW'(sd[NSTEP].b);
        md = vpr_pkg::MW'(sd[NSTEP].f);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[MUL]) begin
      pa  <= ma * mb;
      pb  <= mc * md;
      mz  <= cz[NSTEP];
      msd <= sd[NSTEP];
    end
  end

  // round, saturate and select the result
  vpr_pkg::sat_t  qa30, qb30, qmag, qang, qaf, qbf, qda, qdb;
  vpr_pkg::out_t  res;
  logic signed [vpr_pkg::RW-1:0] mag_sum;

  always_comb begin
    qa30    = vpr_pkg::sat32((vpr_pkg::RW'(pa) + RND_30) >>> 30);
    qb30    = vpr_pkg::sat32((vpr_pkg::RW'(pb) + RND_30) >>> 30);
    mag_sum = vpr_pkg::RW'(pa) + (vpr_pkg::RW'(pb) >>> vpr_pkg::HI_SHIFT) + RND_25;
    qmag    = vpr_pkg::sat32(mag_sum >>> vpr_pkg::HI_SHIFT);
    qang    = vpr_pkg::sat32((vpr_pkg::RW'(mz) + RND_Z) >>> ZSH);
    qaf     = vpr_pkg::sat32((vpr_pkg::RW'(pa) + RND_F) >>> FRAC_BITS);
    qbf     = vpr_pkg::sat32((vpr_pkg::RW'(pb) + RND_F) >>> FRAC_BITS);
    qda     = vpr_pkg::sat32(vpr_pkg::RW'(msd.da));
    qdb     = vpr_pkg::sat32(vpr_pkg::RW'(msd.db));
    res     = '0;
    unique case (msd.op)
      vpr_pkg::CMD_P2R: begin
        res.result_a = qa30.val;
        res.result_b = qb30.val;
        res.overflow = msd.ov | qa30.ov | qb30.ov;
      end
      vpr_pkg::CMD_R2P: begin
        // drop the accumulated angle for the zero vector
        res.result_a = qmag.val;
        res.result_b = msd.origin ? '0 : qang.val;
        res.overflow = qmag.ov | (qang.ov & !msd.origin);
      end
      vpr_pkg::CMD_ADD, vpr_pkg::CMD_SUB, vpr_pkg::CMD_NEG: begin
        res.result_a = qda.val;
        res.result_b = qdb.val;
        res.overflow = qda.ov | qdb.ov;
      end
      vpr_pkg::CMD_SCALE: begin
        res.result_a = qaf.val;
        res.result_b = qbf.val;
        res.overflow = qaf.ov | qbf.ov;
      end
      default: begin
      end
    endcase
  end

  // hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (en[LAST]) out_ch.data <= res;
  end

endmodule
